/* sv/bmhc_pkg.sv */
// Package for the blind motor H-bridge controller.
// Holds word types, command and status codes, register indexes and reset values.
// No dependencies.
package bmhc_pkg;

   // Default full-scale PWM count, handed to the top level parameter.
   localparam int unsigned PWM_FULL_DEFAULT = 1023;

   // Target = floor(speed * full / 100), computed as (speed * recip) >> shift.
   localparam int unsigned RECIP_SHIFT = 14;

   localparam int unsigned SPEED_W = 7;
   localparam int unsigned DUR_W   = 20;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_DUR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_DUR = 2'd2;

   localparam logic [SPEED_W-1:0] SPEED_RESET     = 7'd100;
   localparam logic [DUR_W-1:0]   OPEN_DUR_RESET  = 20'd30000;
   localparam logic [DUR_W-1:0]   CLOSE_DUR_RESET = 20'd30000;

   // Command codes carried in the func field.
   localparam logic [2:0] FN_MS_TICK    = 3'd0;
   localparam logic [2:0] FN_RAMP_TICK  = 3'd1;
   localparam logic [2:0] FN_OPEN       = 3'd2;
   localparam logic [2:0] FN_CLOSE      = 3'd3;
   localparam logic [2:0] FN_OPEN_WAIT  = 3'd4;
   localparam logic [2:0] FN_CLOSE_WAIT = 3'd5;
   localparam logic [2:0] FN_BRAKE      = 3'd6;
   localparam logic [2:0] FN_CANCEL     = 3'd7;

   // Motor direction.
   localparam logic DIR_OPEN  = 1'b0;
   localparam logic DIR_CLOSE = 1'b1;

   typedef enum logic [1:0] {
      ST_OPENED = 2'd0,
      ST_CLOSED = 2'd1,
      ST_UNDEF  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0] func;
      logic       force_req;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [1:0] blind_status;
      logic       motor_dir;
      logic       bridge_disable;
      logic [9:0] pwm_level;
      logic       led_on;
      logic       status_event;
   } rsp_type;

endpackage

/* sv/blind_motor_hbridge_controller.sv */
// Top level of the blind motor H-bridge controller.
// Depends on bmhc_pkg for word types, command codes and register indexes.
//
// Usage:
//   req channel (valid/ready) carries one command word: a ms tick, a ramp tick,
//   open/close (optionally with a timed stop), brake or cancel-timers.
//   rsp channel (valid/ready) returns exactly one word per request with the
//   accept flag, blind status, direction, bridge disable, PWM level, LED and
//   the timer-expiry event, all as they stand after the command.
//   csr port is a plain write port: speed in percent, open and close run
//   times in milliseconds. Write it only while no word is in flight.
// Timing:
//   All state updates in the cycle a request is taken; the response is registered in
//   the output register. One word per cycle sustained while rsp_ready stays high.
//   A skid register behind the output register lets one more request in while
//   the receiver stalls; req_ready drops only when both are full.
// Reset:
//   Synchronous, active high. Status opened, bridge disabled (coasting), PWM
//   and timers cleared, registers back to 100 percent and 30000 ms.
module blind_motor_hbridge_controller
   import bmhc_pkg::*;
#(
   parameter int unsigned PWM_FULL = PWM_FULL_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // PWM width follows the full-scale count.
   localparam int unsigned PWM_W   = $clog2(PWM_FULL + 1);
   // Reciprocal of 100 scaled by full scale, rounded up; exact for 7-bit speeds.
   localparam longint unsigned RECIP_VAL =
      ((longint'(PWM_FULL) << RECIP_SHIFT) + 99) / 100;
   localparam int unsigned RECIP_W = $clog2(RECIP_VAL + 1);
   localparam int unsigned PROD_W  = SPEED_W + RECIP_W;
   localparam int unsigned QUOT_W  = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_VAL);
   localparam logic [QUOT_W-1:0]  FULL_Q = QUOT_W'(PWM_FULL);
   localparam logic [PWM_W-1:0]   FULL_P = PWM_W'(PWM_FULL);

   // Configuration registers.
   logic [SPEED_W-1:0] speed_ff;
   logic [DUR_W-1:0]   open_dur_ff;
   logic [DUR_W-1:0]   close_dur_ff;

   // Controller state.
   status_type       status_ff, status_in;
   logic             dir_ff, dir_in;
   logic             disable_ff, disable_in;
   logic             led_ff, led_in;
   logic [PWM_W-1:0] pwm_ff, pwm_in;
   logic [PWM_W-1:0] target_ff, target_in;
   logic [DUR_W-1:0] open_left_ff, open_left_in;
   logic [DUR_W-1:0] close_left_ff, close_left_in;
   logic             open_armed_ff, open_armed_in;
   logic             close_armed_ff, close_armed_in;

   // Output register and skid register.
   logic    rsp_valid_ff;
   rsp_type rsp_word_ff;
   logic    skid_valid_ff;
   rsp_type skid_word_ff;

   logic             push;
   logic             pop;
   logic             acc;
   logic             evt;
   logic             move_req;
   logic             move_dir;
   logic             arm_open;
   logic             arm_close;
   logic             refuse;
   logic [DUR_W-1:0] open_dec;
   logic [DUR_W-1:0] close_dec;
   logic [PROD_W-1:0] speed_prod;
   logic [QUOT_W-1:0] speed_quot;
   logic [PWM_W-1:0]  ramp_goal;
   logic [PWM_W+9:0]  pwm_ext;
   rsp_type           new_word;

   assign push      = req_valid & req_ready;
   assign pop       = rsp_valid_ff & rsp_ready;
   assign req_ready = ~skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Ramp target from speed, saturated at full scale for speeds above 100.
   assign speed_prod = PROD_W'(speed_ff) * PROD_W'(RECIP);
   assign speed_quot = speed_prod[PROD_W-1:RECIP_SHIFT];
   assign ramp_goal  = (speed_quot > FULL_Q) ? FULL_P : speed_quot[PWM_W-1:0];

   // Countdowns stick at zero.
   assign open_dec  = (open_left_ff != '0) ? open_left_ff - 1'b1 : '0;
   assign close_dec = (close_left_ff != '0) ? close_left_ff - 1'b1 : '0;

   // Next state for the word on the request side.
   always_comb begin
      status_in      = status_ff;
      dir_in         = dir_ff;
      disable_in     = disable_ff;
      led_in         = led_ff;
      pwm_in         = pwm_ff;
      target_in      = target_ff;
      open_left_in   = open_left_ff;
      close_left_in  = close_left_ff;
      open_armed_in  = open_armed_ff;
      close_armed_in = close_armed_ff;
      acc            = 1'b1;
      evt            = 1'b0;
      move_req       = 1'b0;
      move_dir       = DIR_OPEN;
      arm_open       = 1'b0;
      arm_close      = 1'b0;
      refuse         = 1'b0;

      unique case (req_word.func)
         FN_MS_TICK: begin
            // Open expiry first, then close: close wins when both expire.
            if (open_armed_ff) begin
               open_left_in = open_dec;
               if (open_dec == '0) begin
                  open_armed_in = 1'b0;
                  disable_in    = 1'b0;
                  pwm_in        = '0;
                  target_in     = '0;
                  led_in        = 1'b0;
                  status_in     = ST_OPENED;
                  evt           = 1'b1;
               end
            end
            if (close_armed_ff) begin
               close_left_in = close_dec;
               if (close_dec == '0) begin
                  close_armed_in = 1'b0;
                  disable_in     = 1'b0;
                  pwm_in         = '0;
                  target_in      = '0;
                  led_in         = 1'b0;
                  status_in      = ST_CLOSED;
                  evt            = 1'b1;
               end
            end
         end
         FN_RAMP_TICK: begin
            if (pwm_ff < target_ff) begin
               pwm_in = pwm_ff + 1'b1;
            end
         end
         FN_OPEN: begin
            move_req = 1'b1;
            move_dir = DIR_OPEN;
         end
         FN_CLOSE: begin
            move_req = 1'b1;
            move_dir = DIR_CLOSE;
         end
         FN_OPEN_WAIT: begin
            move_req = 1'b1;
            move_dir = DIR_OPEN;
            arm_open = 1'b1;
         end
         FN_CLOSE_WAIT: begin
            move_req  = 1'b1;
            move_dir  = DIR_CLOSE;
            arm_close = 1'b1;
         end
         FN_BRAKE: begin
            disable_in = 1'b0;
            pwm_in     = '0;
            target_in  = '0;
            led_in     = 1'b0;
         end
         FN_CANCEL: begin
            open_armed_in  = 1'b0;
            close_armed_in = 1'b0;
         end
      endcase

      if (move_req) begin
         // Refuse a move into the state the blind already reports.
         refuse = ~req_word.force_req &
                  (status_ff == ((move_dir == DIR_CLOSE) ? ST_CLOSED : ST_OPENED));
         if (refuse) begin
            acc = 1'b0;
         end else begin
            status_in = ST_UNDEF;
            // Leave the drive alone when already running this way.
            if (!(dir_ff == move_dir && pwm_ff != '0 && !disable_ff)) begin
               led_in     = 1'b1;
               dir_in     = move_dir;
               pwm_in     = '0;
               disable_in = 1'b0;
               target_in  = ramp_goal;
            end
            if (arm_open) begin
               open_left_in  = open_dur_ff;
               open_armed_in = 1'b1;
            end
            if (arm_close) begin
               close_left_in  = close_dur_ff;
               close_armed_in = 1'b1;
            end
         end
      end
   end

   assign pwm_ext = {10'd0, pwm_in};

   always_comb begin
      new_word.accepted       = acc;
      new_word.blind_status   = status_in;
      new_word.motor_dir      = dir_in;
      new_word.bridge_disable = disable_in;
      new_word.pwm_level      = pwm_ext[9:0];
      new_word.led_on         = led_in;
      new_word.status_event   = evt;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= SPEED_RESET;
         open_dur_ff  <= OPEN_DUR_RESET;
         close_dur_ff <= CLOSE_DUR_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SPEED) begin
            speed_ff <= csr_wdata[SPEED_W-1:0];
         end
         if (csr_index == CSR_OPEN_DUR) begin
            open_dur_ff <= csr_wdata[DUR_W-1:0];
         end
         if (csr_index == CSR_CLOSE_DUR) begin
            close_dur_ff <= csr_wdata[DUR_W-1:0];
         end
      end
   end

   // Advance the controller state on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff      <= ST_OPENED;
         dir_ff         <= DIR_OPEN;
         disable_ff     <= 1'b1;
         led_ff         <= 1'b0;
         pwm_ff         <= '0;
         target_ff      <= '0;
         open_left_ff   <= '0;
         close_left_ff  <= '0;
         open_armed_ff  <= 1'b0;
         close_armed_ff <= 1'b0;
      end else if (push) begin
         status_ff      <= status_in;
         dir_ff         <= dir_in;
         disable_ff     <= disable_in;
         led_ff         <= led_in;
         pwm_ff         <= pwm_in;
         target_ff      <= target_in;
         open_left_ff   <= open_left_in;
         close_left_ff  <= close_left_in;
         open_armed_ff  <= open_armed_in;
         close_armed_ff <= close_armed_in;
      end
   end

   // Output register with skid: hold the response while stalled, park the
   // next one in the skid register, drain the skid first.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_word_ff <= skid_word_ff;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_word_ff <= new_word;
         end else begin
            skid_word_ff <= new_word;
         end
      end
   end

endmodule

/* sv/bmhc_checker.sv */
// Port-level checks for the blind motor H-bridge controller, with its bind.
// Depends on bmhc_pkg and on the top level's port list.
module bmhc_checker
   import bmhc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_word
);

   // Hold a stalled response word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // Drop everything at reset: no response pending, requests taken.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending after reset");

   // A refused move leaves a final status and raises no event.
   a_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.accepted |->
         rsp_word.blind_status != ST_UNDEF && !rsp_word.status_event)
      else $error("refused word with undefined status or event");

   // A timer expiry leaves the motor braked with a final status.
   a_expiry_brake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status_event |->
         !rsp_word.bridge_disable && rsp_word.pwm_level == '0 &&
         !rsp_word.led_on && rsp_word.blind_status != ST_UNDEF)
      else $error("expiry word not braked");

   // The LED only shows with the bridge enabled.
   a_led_bridge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.led_on |-> !rsp_word.bridge_disable)
      else $error("LED on with bridge disabled");

endmodule

bind blind_motor_hbridge_controller bmhc_checker u_bmhc_checker (.*);

/* tb/tb_blind_motor_hbridge_controller.sv */
// Self-checking testbench for the blind motor H-bridge controller.
// Holds a scoreboard class that predicts each response word, plus the drive tasks.
// Depends on bmhc_pkg and blind_motor_hbridge_controller.
module tb_blind_motor_hbridge_controller;
   import bmhc_pkg::*;

   localparam int unsigned PWM_TOP     = PWM_FULL_DEFAULT;
   // Long receiver stall that lets the request side back up.
   localparam int unsigned HOLD_CYCLES = 60;
   // Cycles to let pass after the last response before touching the CSRs or ending.
   localparam int unsigned SETTLE      = 4;

   // Mirrors the controller state and keeps the queue of predicted response words.
   class motor_scoreboard;
      logic [SPEED_W-1:0] speed;
      logic [DUR_W-1:0]   open_dur;
      logic [DUR_W-1:0]   close_dur;
      status_type         status;
      logic               dir;
      logic               bridge_off;
      logic               led;
      int unsigned        pwm;
      int unsigned        target;
      logic [DUR_W-1:0]   open_left;
      logic [DUR_W-1:0]   close_left;
      bit                 open_armed;
      bit                 close_armed;
      rsp_type            expected_q[$];
      int                 errors;

      function new();
         speed       = SPEED_RESET;
         open_dur    = OPEN_DUR_RESET;
         close_dur   = CLOSE_DUR_RESET;
         status      = ST_OPENED;
         dir         = DIR_OPEN;
         bridge_off  = 1'b1;
         led         = 1'b0;
         pwm         = 0;
         target      = 0;
         open_left   = '0;
         close_left  = '0;
         open_armed  = 1'b0;
         close_armed = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SPEED:     speed     = data[SPEED_W-1:0];
            CSR_OPEN_DUR:  open_dur  = data[DUR_W-1:0];
            CSR_CLOSE_DUR: close_dur = data[DUR_W-1:0];
            default: ;
         endcase
      endfunction

      function void brake();
         bridge_off = 1'b0;
         pwm        = 0;
         target     = 0;
         led        = 1'b0;
      endfunction

      // Refuse when already in the requested state, else run that way.
      function bit move(logic to_dir, logic forced);
         int unsigned goal;
         if (!forced && status == ((to_dir == DIR_CLOSE) ? ST_CLOSED : ST_OPENED))
            return 1'b0;
         status = ST_UNDEF;
         // Already running this way: leave the drive alone.
         if (dir == to_dir && pwm > 0 && !bridge_off)
            return 1'b1;
         led        = 1'b1;
         dir        = to_dir;
         pwm        = 0;
         bridge_off = 1'b0;
         goal       = (int'(speed) * PWM_TOP) / 100;
         target     = (goal > PWM_TOP) ? PWM_TOP : goal;
         return 1'b1;
      endfunction

      // Count one ms; report expiry once the count sits at zero.
      function bit count_ms(inout bit armed, inout logic [DUR_W-1:0] left);
         if (!armed)
            return 1'b0;
         if (left != 0)
            left = left - 1'b1;
         if (left == 0) begin
            armed = 1'b0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(req_type w);
         rsp_type e;
         logic    ok;
         logic    evt;
         ok  = 1'b1;
         evt = 1'b0;
         case (w.func)
            FN_MS_TICK: begin
               // Open is handled first, so a double expiry ends closed.
               if (count_ms(open_armed, open_left)) begin
                  brake();
                  status = ST_OPENED;
                  evt    = 1'b1;
               end
               if (count_ms(close_armed, close_left)) begin
                  brake();
                  status = ST_CLOSED;
                  evt    = 1'b1;
               end
            end
            FN_RAMP_TICK: begin
               if (pwm < target)
                  pwm++;
            end
            FN_OPEN:  ok = move(DIR_OPEN, w.force_req);
            FN_CLOSE: ok = move(DIR_CLOSE, w.force_req);
            FN_OPEN_WAIT: begin
               ok = move(DIR_OPEN, w.force_req);
               if (ok) begin
                  open_left  = open_dur;
                  open_armed = 1'b1;
               end
            end
            FN_CLOSE_WAIT: begin
               ok = move(DIR_CLOSE, w.force_req);
               if (ok) begin
                  close_left  = close_dur;
                  close_armed = 1'b1;
               end
            end
            FN_BRAKE: brake();
            default: begin
               open_armed  = 1'b0;
               close_armed = 1'b0;
            end
         endcase
         e.accepted       = ok;
         e.blind_status   = status;
         e.motor_dir      = dir;
         e.bridge_disable = bridge_off;
         e.pwm_level      = pwm[9:0];
         e.led_on         = led;
         e.status_event   = evt;
         expected_q.push_back(e);
      endfunction

      function string fields(rsp_type r);
         return $sformatf("acc=%0d st=%0d dir=%0d dis=%0d pwm=%0d led=%0d evt=%0d",
                          r.accepted, r.blind_status, r.motor_dir, r.bridge_disable,
                          r.pwm_level, r.led_on, r.status_event);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response word with nothing pending: %s", fields(got));
            return;
         end
         e = expected_q.pop_front();
         if (got.accepted !== e.accepted || got.blind_status !== e.blind_status ||
             got.motor_dir !== e.motor_dir || got.bridge_disable !== e.bridge_disable ||
             got.pwm_level !== e.pwm_level || got.led_on !== e.led_on ||
             got.status_event !== e.status_event) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: expected %s, got %s", $realtime, fields(e), fields(got));
         end
      endfunction

      function int depth();
         return expected_q.size();
      endfunction
   endclass

   // All block inputs start at known values.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Traffic shaping flags, set by the main sequence.
   bit hold_rsp = 1'b0;   // receiver: one long hold-off at its next word
   bit burst    = 1'b0;   // sender: no gaps while the receiver holds off
   bit no_idle  = 1'b0;   // both sides: no gaps at all
   int sent_words = 0;

   motor_scoreboard sb = new();

   blind_motor_hbridge_controller #(
      .PWM_FULL(PWM_TOP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Sample both handshakes at the rising edge, before the block's own updates land.
   // Predict from the accepted request, check the accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_word);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_word);
      end
   end

   // Offer one request word: draw a gap, then hold valid and payload until taken.
   task automatic send_word(logic [2:0] func, logic forced);
      int unsigned gap;
      gap = (no_idle || burst) ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word.func      = func;
      req_word.force_req = forced;
      req_valid          = 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_words++;
   endtask

   // Drop valid, wait for every predicted word to come back, then let the pipe settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.depth() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Write one register; the block must be idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Mostly well-formed runs: a move command, some ramp and ms ticks, then
   // ms ticks toward expiry. The rest is brake/cancel and raw noise.
   task automatic run_random(int count);
      int stop_at;
      int pick;
      int steps;
      stop_at = sent_words + count;
      while (sent_words < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_word(FN_OPEN + 3'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0));
            steps = $urandom_range(0, 12);
            repeat (steps) begin
               if ($urandom_range(0, 9) < 7)
                  send_word(FN_RAMP_TICK, 1'($urandom));
               else
                  send_word(FN_MS_TICK, 1'($urandom));
            end
            steps = $urandom_range(0, 10);
            repeat (steps) send_word(FN_MS_TICK, 1'($urandom));
         end else if (pick < 75) begin
            send_word(($urandom_range(0, 1) == 0) ? FN_BRAKE : FN_CANCEL, 1'($urandom));
         end else begin
            send_word(3'($urandom), 1'($urandom));
         end
      end
   endtask

   // Response side: draw a stall per word, and take one long hold-off on request.
   initial begin : rsp_sink
      int unsigned stall;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : main_seq
      int speeds[6];
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Reset settings: refusal, forced start, ramp, already running, restart, brake.
      send_word(FN_OPEN, 1'b0);        // refused, blind is opened
      send_word(FN_OPEN, 1'b1);        // forced start
      send_word(FN_RAMP_TICK, 1'b0);
      send_word(FN_OPEN, 1'b0);        // already running: drive untouched
      send_word(FN_CLOSE, 1'b0);       // reverse
      send_word(FN_CLOSE, 1'b1);       // pwm still 0: ramp restarts
      send_word(FN_RAMP_TICK, 1'b1);
      send_word(FN_RAMP_TICK, 1'b0);
      send_word(FN_BRAKE, 1'b0);
      send_word(FN_MS_TICK, 1'b0);     // nothing armed
      send_word(FN_CANCEL, 1'b1);
      send_word(FN_RAMP_TICK, 1'b0);   // target cleared by brake
      wait_idle();

      // Saturated speed, shortest durations: both timers expire on one tick.
      write_reg(CSR_SPEED, 20'd127);
      write_reg(CSR_OPEN_DUR, 20'd0);
      write_reg(CSR_CLOSE_DUR, 20'd1);
      send_word(FN_OPEN_WAIT, 1'b1);
      send_word(FN_CLOSE_WAIT, 1'b0);
      send_word(FN_MS_TICK, 1'b0);     // double expiry, status ends closed
      send_word(FN_CLOSE, 1'b0);       // refused
      send_word(FN_CLOSE_WAIT, 1'b0);  // refused, does not arm
      send_word(FN_MS_TICK, 1'b1);
      send_word(FN_OPEN_WAIT, 1'b0);
      send_word(FN_RAMP_TICK, 1'b0);
      send_word(FN_CANCEL, 1'b0);
      send_word(FN_MS_TICK, 1'b0);     // cancelled: no event
      wait_idle();

      // Lowest nonzero speed, longest durations: arm both ways, then cancel.
      write_reg(CSR_SPEED, 20'd1);
      write_reg(CSR_OPEN_DUR, 20'hFFFFF);
      write_reg(CSR_CLOSE_DUR, 20'hFFFFF);
      send_word(FN_OPEN_WAIT, 1'b1);
      send_word(FN_MS_TICK, 1'b0);
      send_word(FN_CLOSE_WAIT, 1'b0);
      send_word(FN_CANCEL, 1'b0);
      send_word(FN_RAMP_TICK, 1'b1);
      send_word(FN_RAMP_TICK, 1'b0);

      speeds[0] = 100;
      speeds[1] = 0;
      speeds[2] = 127;
      speeds[3] = $urandom_range(1, 99);
      speeds[4] = $urandom_range(1, 99);
      speeds[5] = $urandom_range(1, 99);
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         write_reg(CSR_SPEED, 20'(speeds[phase]));
         write_reg(CSR_OPEN_DUR, 20'($urandom_range(0, 8)));
         write_reg(CSR_CLOSE_DUR, 20'($urandom_range(0, 8)));
         no_idle = (phase == 3);
         if (phase == 1) begin
            // Stall the receiver and keep offering words so req_ready drops.
            hold_rsp = 1'b1;
            burst    = 1'b1;
            run_random(40);
            burst    = 1'b0;
         end
         run_random(200);
      end
      no_idle = 1'b0;

      wait_idle();
      if (sb.errors == 0 && sb.depth() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* blind_motor_hbridge_controller.f */
sv/bmhc_pkg.sv
sv/blind_motor_hbridge_controller.sv
sv/bmhc_checker.sv
tb/tb_blind_motor_hbridge_controller.sv
